@@ rtl/core/windowed_event_rate_meter_assert.svh @@
// Assertion macros used by the rate meter top level.
`ifndef WINDOWED_EVENT_RATE_METER_ASSERT_SVH
`define WINDOWED_EVENT_RATE_METER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WERM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define WERM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/werm_pkg.sv @@
// Package: sizes, codes and helpers of the windowed event rate meter.
`timescale 1ns / 1ps
`default_nettype none
package werm_pkg;

	localparam int RING_DEPTH = 16;
	localparam int TIME_BITS  = 32;

	localparam int PTR_BITS  = $clog2(RING_DEPTH);
	localparam int FILL_BITS = $clog2(RING_DEPTH + 1);

	localparam int SCALE_X10 = 10000;
	localparam int RATE_BITS = 18;
	localparam int RATE_MAX  = (1 << RATE_BITS) - 1;

	// dividend (fill - 1) * 10000 and its quotient
	localparam int NUM_BITS = $clog2((RING_DEPTH - 1) * SCALE_X10 + 1);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);
	localparam int QW_BITS  = (NUM_BITS > RATE_BITS) ? NUM_BITS : RATE_BITS;

	localparam int THR_BITS     = 18;
	localparam int TIMEOUT_BITS = 16;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 18;

	localparam logic [THR_BITS-1:0]     BUSY_THR_RESET = 18'd28;
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET  = 16'd2000;

	localparam logic [CFG_IDX_BITS-1:0] CFG_BUSY_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_TIMEOUT   = 1'b1;

	localparam logic CMD_QUERY  = 1'b0;
	localparam logic CMD_RECORD = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [RATE_BITS-1:0] sat_rate(input logic [NUM_BITS-1:0] q);
		logic [QW_BITS-1:0] w;
		w = QW_BITS'(q);
		if (w > QW_BITS'(RATE_MAX))
			return RATE_BITS'(RATE_MAX);
		return w[RATE_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/werm_ring.sv @@
// Ring of event times: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module werm_ring (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [werm_pkg::PTR_BITS-1:0]  waddr,
	input  wire logic [werm_pkg::TIME_BITS-1:0] wdata,
	input  wire logic [werm_pkg::PTR_BITS-1:0]  raddr,
	output logic      [werm_pkg::TIME_BITS-1:0] rdata
);
	import werm_pkg::*;

	logic [TIME_BITS-1:0] mem_q [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/werm_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module werm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [werm_pkg::NUM_BITS-1:0]  dividend,
	input  wire logic [werm_pkg::TIME_BITS-1:0] divisor,
	output werm_pkg::div_stat_t                stat,
	output logic      [werm_pkg::NUM_BITS-1:0]  quotient
);
	import werm_pkg::*;

	logic [TIME_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0]  quo_q;
	logic [TIME_BITS-1:0] dvs_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [TIME_BITS:0] shifted;
	logic [TIME_BITS:0] diff;
	logic               ge;

	// remainder stays below the divisor, so shifted fits one extra bit
	assign shifted = {rem_q, quo_q[NUM_BITS-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
			quo_q <= {quo_q[NUM_BITS-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

@@ rtl/core/windowed_event_rate_meter.sv @@
// Top level: windowed event rate meter, sequencer around ring and divider.
// Path: ST_WRITE, ST_RD_NEW, ST_RD_OLD, ST_CHECK, ST_DIV (one step per bit of the
// default 18-bit dividend), ST_OUT; shorter when the rate reads zero without a divide.
// One item in flight: a new word is taken only in ST_IDLE, after the last result word.
// Reset: state to ST_IDLE, pointer, fill count and out_valid cleared, registers to 28 / 2000;
// the ring contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module windowed_event_rate_meter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              command,
	input  wire logic [werm_pkg::TIME_BITS-1:0]     now_ms,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [werm_pkg::RATE_BITS-1:0]     rate_x10,
	output logic                                   busy_res,
	input  wire logic                              cfg_we,
	input  wire logic [werm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [werm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import werm_pkg::*;

	`include "windowed_event_rate_meter_assert.svh"

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_WRITE  = 7'b0000010,
		ST_RD_NEW = 7'b0000100,
		ST_RD_OLD = 7'b0001000,
		ST_CHECK  = 7'b0010000,
		ST_DIV    = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	localparam int IW = FILL_BITS + 1;

	state_t                state_q;
	logic                  cmd_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [TIME_BITS-1:0]  newest_q;
	logic [PTR_BITS-1:0]   wp_q;
	logic [FILL_BITS-1:0]  fill_q;
	logic [RATE_BITS-1:0]  rate_q;
	logic [THR_BITS-1:0]   thr_q;
	logic [TIMEOUT_BITS-1:0] timeout_q;

	logic [PTR_BITS-1:0]  new_slot;
	logic [PTR_BITS-1:0]  old_slot;
	logic [IW-1:0]        old_sum;
	logic [PTR_BITS-1:0]  raddr;
	logic [TIME_BITS-1:0] rdata;
	logic                 ring_we;
	logic [TIME_BITS-1:0] idle_t;
	logic [TIME_BITS-1:0] span;
	logic                 zero_rate;
	logic                 div_start;
	logic [NUM_BITS-1:0]  dividend;
	logic [NUM_BITS-1:0]  quotient;
	div_stat_t            div_stat;
	logic                 out_stall;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= BUSY_THR_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BUSY_THRESHOLD: thr_q     <= cfg_data[THR_BITS-1:0];
				CFG_IDLE_TIMEOUT:   timeout_q <= cfg_data[TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ring indexes: newest is one behind the pointer, oldest fill behind
	assign new_slot = (wp_q == '0) ? PTR_BITS'(RING_DEPTH - 1) : wp_q - 1'b1;
	assign old_sum  = IW'(wp_q) + IW'(RING_DEPTH) - IW'(fill_q);
	assign old_slot = (old_sum >= IW'(RING_DEPTH)) ?
		PTR_BITS'(old_sum - IW'(RING_DEPTH)) : PTR_BITS'(old_sum);
	assign raddr    = (state_q == ST_RD_NEW) ? new_slot : old_slot;
	assign ring_we  = (state_q == ST_WRITE) && (cmd_q == CMD_RECORD);

	werm_ring u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wp_q),
		.wdata (now_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// in ST_CHECK rdata holds the oldest time
	assign idle_t    = now_q - newest_q;
	assign span      = newest_q - rdata;
	assign zero_rate = (idle_t > TIME_BITS'(timeout_q)) || (span == '0);
	assign div_start = (state_q == ST_CHECK) && !zero_rate;
	assign dividend  = NUM_BITS'(fill_q - 1'b1) * NUM_BITS'(SCALE_X10);

	werm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (span),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_stall = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			fill_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			// in ST_OUT the arm below owns out_valid
			if (out_valid && out_ready && state_q != ST_OUT)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (cmd_q == CMD_RECORD) begin
						wp_q <= (wp_q == PTR_BITS'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
						if (fill_q != FILL_BITS'(RING_DEPTH))
							fill_q <= fill_q + 1'b1;
					end
					state_q <= ST_RD_NEW;
				end
				ST_RD_NEW: begin
					state_q <= (fill_q < FILL_BITS'(2)) ? ST_OUT : ST_RD_OLD;
				end
				ST_RD_OLD: state_q <= ST_CHECK;
				ST_CHECK:  state_q <= zero_rate ? ST_OUT : ST_DIV;
				ST_DIV: begin
					if (div_stat.done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			now_q <= now_ms;
		end
		if (state_q == ST_RD_OLD)
			newest_q <= rdata;
		if (state_q == ST_RD_NEW || state_q == ST_CHECK)
			rate_q <= '0;
		if (state_q == ST_DIV && div_stat.done)
			rate_q <= sat_rate(quotient);
		if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			rate_x10 <= rate_q;
			busy_res <= (rate_q >= thr_q);
		end
	end

	`WERM_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_BITS'(RING_DEPTH), "fill count above depth")
	`WERM_ASSERT_NOW(a_div_in_div, div_stat.done, state_q == ST_DIV, "divider done outside divide")
	`WERM_ASSERT_NOW(a_div_busy, div_stat.busy, state_q == ST_DIV, "divider busy outside divide")
	`WERM_ASSERT_NEXT(a_out_hold, (state_q == ST_OUT) && out_stall, state_q == ST_OUT, "result word overrun")
	`WERM_ASSERT_NEXT(a_accept_go, in_valid && in_ready, state_q == ST_WRITE, "accepted word not started")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for the windowed event rate meter: random traffic, scoreboard, config phases.
`timescale 1ns / 1ps
module tb_top;
	import werm_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_WORDS  = 190;

	typedef struct {
		logic                 cmd;
		logic [TIME_BITS-1:0] t;
	} key_word_t;

	typedef struct {
		logic [RATE_BITS-1:0] rate;
		logic                 busy;
	} rate_word_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic                     command   = CMD_QUERY;
	logic [TIME_BITS-1:0]     now_ms    = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [RATE_BITS-1:0]     rate_x10;
	logic                     busy_res;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_BUSY_THRESHOLD;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	// stimulus still to be sent and rates still to come back
	key_word_t  key_words[$];
	rate_word_t pending_rates[$];

	// shadow of the meter state
	logic [TIME_BITS-1:0]    event_ring[RING_DEPTH];
	logic [PTR_BITS-1:0]     ring_wp   = '0;
	logic [FILL_BITS-1:0]    ring_fill = '0;
	logic [THR_BITS-1:0]     busy_thr  = BUSY_THR_RESET;
	logic [TIMEOUT_BITS-1:0] idle_to   = TIMEOUT_RESET;

	int send_gap_pct   = 7;
	int recv_stall_pct = 80;
	int mismatches     = 0;
	int stall_cycles   = 0;

	windowed_event_rate_meter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rate_x10  (rate_x10),
		.busy_res  (busy_res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// apply one accepted word to the shadow state and queue the rate it must give
	task automatic predict_rate(input logic cmd, input logic [TIME_BITS-1:0] t);
		logic [TIME_BITS-1:0] newest;
		logic [TIME_BITS-1:0] oldest;
		logic [TIME_BITS-1:0] idle;
		logic [TIME_BITS-1:0] span;
		logic [PTR_BITS-1:0]  oldest_slot;
		logic [63:0]          q;
		rate_word_t           want;
		if (cmd == CMD_RECORD) begin
			event_ring[ring_wp] = t;
			ring_wp = ring_wp + 1'b1;
			if (ring_fill < FILL_BITS'(RING_DEPTH))
				ring_fill = ring_fill + 1'b1;
		end
		q = '0;
		if (ring_fill >= 2) begin
			oldest_slot = ring_wp - PTR_BITS'(ring_fill);
			newest = event_ring[PTR_BITS'(ring_wp - 1'b1)];
			oldest = event_ring[oldest_slot];
			idle = t - newest;
			span = newest - oldest;
			if (idle <= TIME_BITS'(idle_to) && span != '0)
				q = (64'(ring_fill - 1'b1) * 64'(SCALE_X10)) / 64'(span);
		end
		if (q > 64'(RATE_MAX))
			q = 64'(RATE_MAX);
		want.rate = q[RATE_BITS-1:0];
		want.busy = (want.rate >= busy_thr);
		pending_rates.push_back(want);
	endtask

	// driver: holds a word until taken, random gaps on both sides
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			command   <= CMD_QUERY;
			now_ms    <= '0;
			out_ready <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				void'(key_words.pop_front());
			if (!(in_valid && !in_ready)) begin
				if (key_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					command  <= key_words[0].cmd;
					now_ms   <= key_words[0].t;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on input handshake, then check output handshake
	always @(posedge clk) begin : monitor
		rate_word_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_rate(command, now_ms);
			if (out_valid && out_ready) begin
				if (pending_rates.size() == 0) begin
					report_mismatch($sformatf("unexpected word rate_x10=%0d busy=%0b",
						rate_x10, busy_res));
				end else begin
					want = pending_rates.pop_front();
					if (rate_x10 !== want.rate)
						report_mismatch($sformatf("rate_x10 %0d, want %0d", rate_x10, want.rate));
					if (busy_res !== want.busy)
						report_mismatch($sformatf("busy_res %0b, want %0b (rate %0d)",
							busy_res, want.busy, want.rate));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic push_word(input logic cmd, input logic [TIME_BITS-1:0] t);
		key_word_t w;
		w.cmd = cmd;
		w.t   = t;
		key_words.push_back(w);
	endtask

	task automatic drain();
		while (key_words.size() != 0 || pending_rates.size() != 0 || in_valid)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BUSY_THRESHOLD)
			busy_thr = data;
		else
			idle_to = data[TIMEOUT_BITS-1:0];
	endtask

	initial begin : stimulus
		logic [TIME_BITS-1:0]    cur_t;
		logic [TIME_BITS-1:0]    last_evt;
		logic [TIME_BITS-1:0]    target;
		logic [THR_BITS-1:0]     thr;
		logic [TIMEOUT_BITS-1:0] tmo;
		logic                    cmd;
		int                      pick;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: times straddle the 32-bit wrap
		@(negedge clk);
		cur_t = 32'hFFFF_FFFF;
		push_word(CMD_QUERY, cur_t);           // empty ring
		push_word(CMD_RECORD, cur_t);          // single event
		push_word(CMD_RECORD, cur_t);          // zero span
		cur_t = cur_t + 1;
		repeat (14) push_word(CMD_RECORD, cur_t); // fill up, span of 1 ms -> top rate
		push_word(CMD_QUERY, cur_t + 32'd2000); // right at the idle limit
		push_word(CMD_QUERY, cur_t + 32'd2001); // just past it
		cur_t = cur_t + 32'd2001;
		push_word(CMD_RECORD, cur_t);
		last_evt = cur_t;
		drain();

		for (int p = 0; p < 6; p++) begin
			send_gap_pct   = (p < 2) ? 7 : (p < 4) ? 80 : 0;
			recv_stall_pct = (p < 2) ? 80 : (p < 4) ? 7 : 0;
			case (p)
				0: begin thr = '0; tmo = '0; end
				1: begin thr = 18'd150000; tmo = 16'hFFFF; end
				2: begin thr = '1; tmo = 16'd2000; end
				3: begin thr = THR_BITS'($urandom_range(30000)); tmo = 16'($urandom_range(5000)); end
				4: begin thr = 18'd20000; tmo = 16'hFFFF; end
				default: begin
					thr = THR_BITS'($urandom_range(150000));
					tmo = 16'($urandom_range(65535));
				end
			endcase
			write_cfg(CFG_BUSY_THRESHOLD, thr);
			write_cfg(CFG_IDLE_TIMEOUT, CFG_DATA_BITS'(tmo));

			@(negedge clk);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				pick = $urandom_range(99);
				cmd  = ($urandom_range(99) < 70) ? CMD_RECORD : CMD_QUERY;
				if (pick < 50) begin
					cur_t = cur_t + $urandom_range(150);
				end else if (pick < 65) begin
					cur_t = cur_t + $urandom_range(3);
				end else if (pick < 85) begin
					// land on the idle boundary relative to the newest event
					target = last_evt + TIME_BITS'(tmo) + TIME_BITS'($urandom_range(2)) - 1;
					if (target - cur_t < 32'h8000_0000)
						cur_t = target;
					else
						cur_t = cur_t + $urandom_range(50);
				end else if (pick < 95) begin
					cur_t = cur_t + $urandom;
				end else begin
					cur_t = 32'hFFFF_FFFF - $urandom_range(20);
				end
				push_word(cmd, cur_t);
				if (cmd == CMD_RECORD)
					last_evt = cur_t;
			end
			drain();
		end

		if (pending_rates.size() != 0)
			report_mismatch($sformatf("%0d rate words never arrived", pending_rates.size()));
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
